/* src/assert_macros.svh */
// Assertion macros used by the checker file of the project.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* src/sqp_pkg.sv */
// Shared types and codes of the sorted priority queue.
// Used by the cell, the top level and the checker; depends on nothing.
package sqp_pkg;

  // Action codes carried by each input transaction.
  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_CLR  = 2'd2,
    ACT_PEEK = 2'd3
  } action_t;

  // Status codes reported with each result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Shift control broadcast to every cell in the row.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

/* src/sorted_priority_queue.sv */
// Top level of the sorted min-priority queue: a row of shifting cells.
// Depends on sqp_pkg and sqp_cell.
//
// The queue takes one transaction in every clock cycle: busy stays low, and
// each transaction's result appears on the result ports, marked by done, in
// the cycle right after start was sampled. The row of cells compares every
// stored priority against the incoming one in parallel, and its shift is
// registered at the same clock edge as the result. The result strobe cannot
// be held off; a receiver must take it in that cycle. Equal priorities leave
// in arrival order.
module sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 32,
  localparam int CNT_BITS     = $clog2(DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [TAG_BITS-1:0]             item_tag,
  input  logic signed [PRIORITY_BITS-1:0] item_priority,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [TAG_BITS-1:0]             removed_tag,
  output logic [TAG_BITS-1:0]             head_tag,
  output logic signed [PRIORITY_BITS-1:0] head_priority,
  output logic [CNT_BITS-1:0]             occupancy,
  output logic                            is_empty
);

  localparam logic [CNT_BITS-1:0] FullCount = CNT_BITS'(DEPTH);

  logic                            accept;
  logic                            is_full;
  logic                            none;
  logic [CNT_BITS-1:0]             count;
  logic [CNT_BITS-1:0]             count_next;
  sqp_pkg::cell_ctrl_t             ctrl;
  logic                            cell_gt   [DEPTH];
  logic [TAG_BITS-1:0]             cell_tag  [DEPTH];
  logic signed [PRIORITY_BITS-1:0] cell_prio [DEPTH];

  // The row finishes every transaction without stalling, so busy is never raised.
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_full = (count == FullCount);
  assign none    = (count == '0);

  // Shift control for the whole row.
  assign ctrl.insert = accept && (action == sqp_pkg::ACT_ENQ) && !is_full;
  assign ctrl.remove = accept && (action == sqp_pkg::ACT_DEQ) && !none;

  // Occupancy after the transaction.
  always_comb begin
    count_next = count;
    if (accept) begin
      if (action == sqp_pkg::ACT_CLR) begin
        count_next = '0;
      end else if (ctrl.insert) begin
        count_next = count + 1'b1;
      end else if (ctrl.remove) begin
        count_next = count - 1'b1;
      end
    end
  end

  // Row of cells; the last one feeds itself on a remove.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                            occ;
    logic                            lgt;
    logic [TAG_BITS-1:0]             ltag;
    logic signed [PRIORITY_BITS-1:0] lprio;
    logic [TAG_BITS-1:0]             rtag;
    logic signed [PRIORITY_BITS-1:0] rprio;

    assign occ = (count > CNT_BITS'(i));

    if (i == 0) begin : g_first
      assign lgt   = 1'b0;
      assign ltag  = item_tag;
      assign lprio = item_priority;
    end else begin : g_inner
      assign lgt   = cell_gt[i-1];
      assign ltag  = cell_tag[i-1];
      assign lprio = cell_prio[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rtag  = cell_tag[i];
      assign rprio = cell_prio[i];
    end else begin : g_body
      assign rtag  = cell_tag[i+1];
      assign rprio = cell_prio[i+1];
    end

    sqp_cell #(
      .TAG_BITS      (TAG_BITS),
      .PRIORITY_BITS (PRIORITY_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_tag    (item_tag),
      .new_prio   (item_priority),
      .occupied   (occ),
      .left_gt    (lgt),
      .left_tag   (ltag),
      .left_prio  (lprio),
      .right_tag  (rtag),
      .right_prio (rprio),
      .gt         (cell_gt[i]),
      .tag        (cell_tag[i]),
      .prio       (cell_prio[i])
    );
  end

  // Control registers: occupancy and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= sqp_pkg::ST_OK;
      removed_tag <= '0;
      if (action == sqp_pkg::ACT_ENQ && is_full) begin
        status <= sqp_pkg::ST_FULL;
      end else if (action == sqp_pkg::ACT_DEQ) begin
        if (none) begin
          status <= sqp_pkg::ST_EMPTY;
        end else begin
          removed_tag <= cell_tag[0];
        end
      end
    end
  end

  // Head entry and occupancy follow the row directly.
  assign occupancy     = count;
  assign is_empty      = none;
  assign head_tag      = none ? '0 : cell_tag[0];
  assign head_priority = none ? '0 : cell_prio[0];

endmodule

/* src/sqp_cell.sv */
// One storage cell of the sorted queue row.
// Depends on sqp_pkg for the shift control struct.
module sqp_cell #(
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 32
) (
  input  logic                            clk,
  input  sqp_pkg::cell_ctrl_t             ctrl,
  input  logic [TAG_BITS-1:0]             new_tag,
  input  logic signed [PRIORITY_BITS-1:0] new_prio,
  input  logic                            occupied,
  input  logic                            left_gt,
  input  logic [TAG_BITS-1:0]             left_tag,
  input  logic signed [PRIORITY_BITS-1:0] left_prio,
  input  logic [TAG_BITS-1:0]             right_tag,
  input  logic signed [PRIORITY_BITS-1:0] right_prio,
  output logic                            gt,
  output logic [TAG_BITS-1:0]             tag,
  output logic signed [PRIORITY_BITS-1:0] prio
);

  // The new entry must go ahead of this one when this one is strictly larger.
  assign gt = occupied && (prio > new_prio);

  // On insert, cells past the insertion point take their left neighbor,
  // the cell at the insertion point takes the new entry. On remove, every
  // cell takes its right neighbor.
  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_gt) begin
        tag  <= left_tag;
        prio <= left_prio;
      end else if (gt || !occupied) begin
        tag  <= new_tag;
        prio <= new_prio;
      end
    end else if (ctrl.remove) begin
      tag  <= right_tag;
      prio <= right_prio;
    end
  end

endmodule

/* src/sqp_checker.sv */
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on sqp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sqp_checker #(
  parameter int DEPTH         = 16,
  parameter int TAG_BITS      = 16,
  parameter int PRIORITY_BITS = 32,
  parameter int CNT_BITS      = $clog2(DEPTH + 1)
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [1:0]                      status,
  input logic [TAG_BITS-1:0]             head_tag,
  input logic signed [PRIORITY_BITS-1:0] head_priority,
  input logic [CNT_BITS-1:0]             occupancy,
  input logic                            is_empty
);

  // Every accepted transaction gets its result in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, done)

  // A result never appears without a transaction before it.
  `ASSERT_IMPL(a_no_spurious, clk, rst, done, $past(start && !busy))

  // A rejected enqueue is reported only with a full queue.
  `ASSERT_IMPL(a_full_count, clk, rst, done && status == sqp_pkg::ST_FULL, occupancy == CNT_BITS'(DEPTH))

  // An empty queue shows no head entry.
  `ASSERT_IMPL(a_empty_head, clk, rst, done && is_empty, occupancy == '0 && head_tag == '0 && head_priority == '0)

endmodule

bind sorted_priority_queue sqp_checker #(
  .DEPTH         (DEPTH),
  .TAG_BITS      (TAG_BITS),
  .PRIORITY_BITS (PRIORITY_BITS),
  .CNT_BITS      (CNT_BITS)
) u_sqp_checker (.*);
